@@ rtl/core/ucjk_pkg.sv @@
// ----------------------------------------------------------------------------
// ucjk_pkg: shared types and constants for the UTF-8 CJK presence detector
// Holds the byte-stage item layout, the decoder state layout, the UTF-8
// lead/continuation masks and the ideograph range bounds.
// ----------------------------------------------------------------------------
`default_nettype none

package ucjk_pkg;

  // One byte of the message together with its end-of-message mark.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } ucjk_beat_t;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [1:0] bytes_pending;
    logic [9:0] partial_point;
    logic       found_flag;
  } ucjk_state_t;

  // UTF-8 byte classification masks and tags.
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD2_PAY  = 8'h1F;
  localparam logic [7:0] LEAD3_PAY  = 8'h0F;

  // Code point bounds of the two ideograph blocks.
  localparam logic [15:0] UNIFIED_LO = 16'h4E00;
  localparam logic [15:0] UNIFIED_HI = 16'h9FFF;
  localparam logic [15:0] EXT_A_LO   = 16'h3400;
  localparam logic [15:0] EXT_A_HI   = 16'h4DBF;

  // True when the code point is a CJK ideograph of either block.
  function automatic logic is_cjk(input logic [15:0] cp);
    is_cjk = ((cp >= UNIFIED_LO) && (cp <= UNIFIED_HI)) ||
             ((cp >= EXT_A_LO) && (cp <= EXT_A_HI));
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ucjk_decode.sv @@
// ----------------------------------------------------------------------------
// ucjk_decode: UTF-8 sequence decoder with sticky ideograph flag
// Holds the pending-byte count, the partial code point and the found flag,
// and advances them by one byte whenever step_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ucjk_decode (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   step_en,
  input  ucjk_pkg::ucjk_beat_t  beat,
  output logic                  found_now
);

  ucjk_pkg::ucjk_state_t state_r;
  ucjk_pkg::ucjk_state_t state_nxt;

  logic [7:0]  b;
  logic        is_cont;
  logic [15:0] cp;
  logic [1:0]  pend_dec;
  logic        hit;

  // Decode one byte against the current state.
  always_comb begin
    b         = beat.text_byte;
    is_cont   = ((b & ucjk_pkg::CONT_MASK) == ucjk_pkg::CONT_TAG);
    cp        = {state_r.partial_point, b[5:0]};
    pend_dec  = state_r.bytes_pending - 2'd1;
    hit       = 1'b0;
    state_nxt = state_r;
    if ((state_r.bytes_pending != 2'd0) && is_cont) begin
      // A continuation byte extends the pending sequence.
      state_nxt.bytes_pending = pend_dec;
      if (pend_dec == 2'd0) begin
        hit                     = ucjk_pkg::is_cjk(cp);
        state_nxt.partial_point = 10'd0;
      end else begin
        state_nxt.partial_point = cp[9:0];
      end
    end else begin
      // Any other byte starts a new sequence; a broken one is dropped.
      priority if ((b & ucjk_pkg::ASCII_MASK) == 8'h00) begin
        state_nxt.bytes_pending = 2'd0;
        state_nxt.partial_point = 10'd0;
      end else if ((b & ucjk_pkg::LEAD2_MASK) == ucjk_pkg::LEAD2_TAG) begin
        state_nxt.bytes_pending = 2'd1;
        state_nxt.partial_point = {2'b00, b & ucjk_pkg::LEAD2_PAY};
      end else if ((b & ucjk_pkg::LEAD3_MASK) == ucjk_pkg::LEAD3_TAG) begin
        state_nxt.bytes_pending = 2'd2;
        state_nxt.partial_point = {2'b00, b & ucjk_pkg::LEAD3_PAY};
      end else begin
        // Stray continuation or four-byte/invalid lead is skipped.
        state_nxt.bytes_pending = 2'd0;
        state_nxt.partial_point = 10'd0;
      end
    end
    found_now            = state_r.found_flag | hit;
    state_nxt.found_flag = found_now;
    // The last byte of a message clears everything for the next one.
    if (beat.is_last) begin
      state_nxt = '0;
    end
  end

  // State register, advanced once per byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utf8_cjk_presence_detector.sv @@
// ----------------------------------------------------------------------------
// utf8_cjk_presence_detector: flags CJK ideographs in a UTF-8 message
// Input byte register, single-pass decoder and registered result.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one message byte per item in in_tdata, with
//   in_tlast high on the final byte of the message. For every byte marked
//   last, the master channel returns one item whose bit 0 of out_tdata says
//   whether any decoded code point of that message lies in 0x3400-0x4DBF or
//   0x4E00-0x9FFF. Other bytes produce no item.
//   Throughput is one byte per cycle while the result register can take a
//   result: the input register feeds the decoder and the decoder updates its
//   state as the byte leaves it, so a new byte is taken every cycle unless a
//   last byte is held. A last byte passes from the input register to the
//   result register, which drives out_tvalid.
//   When the receiver stalls, the result register holds its item; bytes that
//   are not last keep flowing, and a last byte waits in the input register,
//   with in_tready low, until the result register frees.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   decoder state, so the next byte starts a new message.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_cjk_presence_detector (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] text_byte
  input  wire        in_tlast,   // is_last
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata   // [0] has_cjk, [7:1] zero
);

  logic                 stg_valid_r;
  ucjk_pkg::ucjk_beat_t stg_beat_r;
  logic                 out_valid_r;
  logic                 out_flag_r;
  logic                 out_free;
  logic                 stg_go;
  logic                 found_now;

  // Handshake control between the input register and the result register.
  assign out_free  = !out_valid_r || out_tready;
  assign stg_go    = stg_valid_r && (!stg_beat_r.is_last || out_free);
  assign in_tready = !stg_valid_r || stg_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_beat_r.text_byte <= in_tdata;
      stg_beat_r.is_last   <= in_tlast;
    end
  end

  // Decoder state and ideograph detection.
  ucjk_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (stg_go),
    .beat      (stg_beat_r),
    .found_now (found_now)
  );

  // Result register, loaded on the last byte of a message.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_go && stg_beat_r.is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go && stg_beat_r.is_last) begin
      out_flag_r <= found_now;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_flag_r};

endmodule

`default_nettype wire

@@ tb/tb_utf8_cjk_presence_detector.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_cjk_presence_detector: self-checking bench for the CJK detector
// Streams UTF-8 messages byte by byte into the slave channel and compares
// each result item against a cycle-free bench model or a typed-in flag.
// A short table of directed bytes covers the range bounds and the malformed
// inputs, then random messages follow under varying idle and stall rates.
// ----------------------------------------------------------------------------

module tb_utf8_cjk_presence_detector;

  // How a directed row's result is obtained.
  typedef enum logic [1:0] {
    RES_MODEL,
    RES_CLEAR,
    RES_FOUND
  } res_kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
    res_kind_t  res;
  } dir_row_t;

  localparam int DIR_N      = 27;
  localparam int RAND_BYTES = 1900;
  localparam int MAX_REPORT = 10;

  // Directed bytes: ideograph bounds, the gap between the blocks and the
  // malformed cases. Results are typed in where they are obvious.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{8'h00, 1'b1, RES_CLEAR},                              // lowest byte alone
    '{8'hFF, 1'b1, RES_CLEAR},                              // invalid lead alone
    '{8'hE4, 1'b0, RES_MODEL}, '{8'hB8, 1'b0, RES_MODEL},
    '{8'h80, 1'b1, RES_FOUND},                              // U+4E00, done by last
    '{8'hE4, 1'b0, RES_MODEL}, '{8'hB6, 1'b0, RES_MODEL},
    '{8'hBF, 1'b1, RES_FOUND},                              // U+4DBF
    '{8'hE3, 1'b0, RES_MODEL}, '{8'h90, 1'b0, RES_MODEL},
    '{8'h80, 1'b1, RES_FOUND},                              // U+3400
    '{8'hE9, 1'b0, RES_MODEL}, '{8'hBF, 1'b0, RES_MODEL},
    '{8'hBF, 1'b1, RES_FOUND},                              // U+9FFF
    '{8'hE4, 1'b0, RES_MODEL}, '{8'hB7, 1'b0, RES_MODEL},
    '{8'h80, 1'b1, RES_MODEL},                              // U+4DC0, in the gap
    '{8'hE4, 1'b0, RES_MODEL}, '{8'hB8, 1'b1, RES_CLEAR},   // cut off at the end
    '{8'hE4, 1'b0, RES_MODEL}, '{8'h41, 1'b0, RES_MODEL},   // broken sequence
    '{8'hB8, 1'b0, RES_MODEL}, '{8'h80, 1'b1, RES_CLEAR},   // then stray bytes
    '{8'hF0, 1'b0, RES_MODEL}, '{8'h80, 1'b1, RES_CLEAR},   // four-byte lead
    '{8'hC3, 1'b0, RES_MODEL}, '{8'hA9, 1'b1, RES_MODEL}    // two-byte form
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;    // [7:0] text_byte
  logic       in_tlast = 1'b0;     // is_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [0] has_cjk, [7:1] zero
  res_kind_t  row_res = RES_MODEL;

  // Decoder model state.
  logic [1:0] pend_q;
  logic [9:0] part_q;
  logic       found_q;

  // Expected flags in message order, oldest at the read pointer.
  logic        flag_mem [4096];
  logic [11:0] flag_wr_ptr = 12'd0;
  logic [11:0] flag_rd_ptr = 12'd0;
  int          flag_cnt = 0;

  // Bytes of the message being built.
  logic [7:0] msg_mem [64];
  int         msg_len = 0;

  int snd_idle_pct = 7;
  int rcv_idle_pct = 47;
  int sent_cnt = 0;
  int byte_cnt = 0;
  int msg_cnt = 0;
  int found_cnt = 0;
  int mismatch_cnt = 0;

  utf8_cjk_presence_detector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the decoder model by one message byte.
  task automatic scan_byte(input logic [7:0] b);
    logic [15:0] cp;
    if (pend_q != 2'd0 && (b & ucjk_pkg::CONT_MASK) == ucjk_pkg::CONT_TAG) begin
      cp = {part_q, b[5:0]};
      pend_q = pend_q - 2'd1;
      if (pend_q == 2'd0) begin
        if (ucjk_pkg::is_cjk(cp))
          found_q = 1'b1;
        part_q = '0;
      end else begin
        part_q = cp[9:0];
      end
    end else if ((b & ucjk_pkg::LEAD2_MASK) == ucjk_pkg::LEAD2_TAG) begin
      pend_q = 2'd1;
      part_q = {5'b0, b[4:0]};
    end else if ((b & ucjk_pkg::LEAD3_MASK) == ucjk_pkg::LEAD3_TAG) begin
      pend_q = 2'd2;
      part_q = {6'b0, b[3:0]};
    end else begin
      // ASCII, stray continuation, or a four-byte or invalid lead.
      pend_q = 2'd0;
      part_q = '0;
    end
  endtask

  task automatic note_mismatch(input logic [7:0] exp_byte, input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORT)
      $display("%0t: %s: expected %02h, got %02h", $realtime, what, exp_byte, out_tdata);
  endtask

  // Track accepted bytes and check each result item against the oldest flag.
  always @(posedge clk) begin : monitor
    logic exp_flag;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        scan_byte(in_tdata);
        byte_cnt++;
        if (in_tlast) begin
          unique case (row_res)
            RES_FOUND: exp_flag = 1'b1;
            RES_CLEAR: exp_flag = 1'b0;
            default:   exp_flag = found_q;
          endcase
          flag_mem[flag_wr_ptr] = exp_flag;
          flag_wr_ptr = flag_wr_ptr + 12'd1;
          flag_cnt++;
          msg_cnt++;
          pend_q  = '0;
          part_q  = '0;
          found_q = 1'b0;
        end
      end
      if (out_tvalid && out_tready) begin
        if (flag_cnt == 0) begin
          note_mismatch(8'h00, "result item with none pending");
        end else begin
          exp_flag = flag_mem[flag_rd_ptr];
          flag_rd_ptr = flag_rd_ptr + 12'd1;
          flag_cnt--;
          if (exp_flag)
            found_cnt++;
          if (out_tdata !== {7'b0, exp_flag})
            note_mismatch({7'b0, exp_flag}, "has_cjk mismatch");
        end
      end
    end
  end

  // Receiver: random stalls at the current rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Send one byte, with random idle cycles ahead of it.
  task automatic send_item(input logic [7:0] b, input logic l, input res_kind_t rk);
    if (sent_cnt < 640) begin
      snd_idle_pct = 7;
      rcv_idle_pct = 47;
    end else if (sent_cnt < 1280) begin
      snd_idle_pct = 47;
      rcv_idle_pct = 7;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    row_res   <= rk;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_cnt++;
  endtask

  // Append one byte to the message being built.
  task automatic add_byte(input logic [7:0] v);
    msg_mem[6'(msg_len)] = v;
    msg_len++;
  endtask

  task automatic push_three(input logic [15:0] cp);
    add_byte({4'hE, cp[15:12]});
    add_byte({2'b10, cp[11:6]});
    add_byte({2'b10, cp[5:0]});
  endtask

  // Build one random message: mostly well-formed text, some malformed bytes.
  task automatic build_message();
    int n_chars;
    int kind;
    logic with_cjk;
    logic [15:0] cp;
    msg_len  = 0;
    n_chars  = $urandom_range(12, 1);
    with_cjk = 1'($urandom_range(1));
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(99);
      if (kind < 35 || (kind >= 65 && kind < 80 && !with_cjk)) begin
        add_byte({1'b0, 7'($urandom_range(127))});
      end else if (kind < 50) begin
        add_byte({3'b110, 5'($urandom_range(31))});
        add_byte({2'b10, 6'($urandom_range(63))});
      end else if (kind < 65) begin
        push_three(16'($urandom_range(16'hFFFF)));
      end else if (kind < 80) begin
        // Ideographs, weighted toward the block bounds and their neighbors.
        case ($urandom_range(9))
          0:       cp = ucjk_pkg::EXT_A_LO;
          1:       cp = ucjk_pkg::EXT_A_HI;
          2:       cp = ucjk_pkg::UNIFIED_LO;
          3:       cp = ucjk_pkg::UNIFIED_HI;
          4:       cp = ucjk_pkg::EXT_A_LO - 16'd1;
          5:       cp = ucjk_pkg::EXT_A_HI + 16'd1;
          6:       cp = ucjk_pkg::UNIFIED_LO - 16'd1;
          7:       cp = ucjk_pkg::UNIFIED_HI + 16'd1;
          8:       cp = ucjk_pkg::EXT_A_LO + 16'($urandom_range(16'h19BF));
          default: cp = ucjk_pkg::UNIFIED_LO + 16'($urandom_range(16'h51FF));
        endcase
        push_three(cp);
      end else if (kind < 88) begin
        // Truncated three-byte sequence; the next character breaks it.
        add_byte({4'hE, 4'($urandom_range(15))});
        if ($urandom_range(1))
          add_byte({2'b10, 6'($urandom_range(63))});
      end else if (kind < 94) begin
        add_byte({2'b10, 6'($urandom_range(63))});
      end else if (kind < 97) begin
        add_byte({4'hF, 4'($urandom_range(15))});
        repeat (3) add_byte({2'b10, 6'($urandom_range(63))});
      end else begin
        add_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    pend_q  = '0;
    part_q  = '0;
    found_q = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < DIR_N; i++)
      send_item(DIR_ROWS[i].text_byte, DIR_ROWS[i].is_last, DIR_ROWS[i].res);

    // Random messages.
    while (sent_cnt < DIR_N + RAND_BYTES) begin
      build_message();
      for (int i = 0; i < msg_len; i++)
        send_item(msg_mem[6'(i)], (i == msg_len - 1), RES_MODEL);
    end
    in_tvalid <= 1'b0;

    // Drain, then allow for the pipeline latency.
    while (flag_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d messages; %0d results reported ideographs.",
             byte_cnt, msg_cnt, found_cnt);
    $display("Mismatches: %0d.", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest expected run.
  initial begin
    #800000;
    $display("Timeout with %0d results outstanding.", flag_cnt);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ utf8_cjk_presence_detector.f @@
rtl/core/ucjk_pkg.sv
rtl/core/ucjk_decode.sv
rtl/core/utf8_cjk_presence_detector.sv
tb/tb_utf8_cjk_presence_detector.sv
